[hw/rtl/v4n_pkg.sv]
`default_nettype none

package v4n_pkg;

   localparam int NumComp = 4;
   localparam int CompW   = 32;
   localparam int SqW     = 2 * CompW;
   localparam int SumW    = SqW + 2;
   localparam int RootW   = 33;
   localparam int RemW    = 36;
   localparam int QuotW   = 31;
   localparam int DRemW   = 33;
   localparam int UnitW   = 32;

   typedef logic [NumComp-1:0][CompW-1:0] v4n_vec_type;

   // component sizes and signs, carried alongside the length calculation
   typedef struct packed {
      logic [NumComp-1:0][CompW-1:0] mag;
      logic [NumComp-1:0]            neg;
   } v4n_item_type;

endpackage

`default_nettype wire

[hw/rtl/v4n_square.sv]
`default_nettype none

module v4n_square (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire v4n_pkg::v4n_vec_type  in_comp,
   output logic                       out_valid,
   output v4n_pkg::v4n_item_type      out_item,
   output logic [v4n_pkg::SumW-1:0]   out_sum
);

   logic                                          v1_ff, v2_ff, v3_ff;
   v4n_pkg::v4n_item_type                         item1_in, item1_ff, item2_ff, item3_ff;
   logic [v4n_pkg::NumComp-1:0][v4n_pkg::SqW-1:0] sq_in, sq_ff;
   logic [v4n_pkg::SumW-1:0]                      sum_in, sum_ff;

   always_comb begin
      for (int i = 0; i < v4n_pkg::NumComp; i++) begin
         item1_in.neg[i] = in_comp[i][v4n_pkg::CompW-1];
         item1_in.mag[i] = item1_in.neg[i] ? (~in_comp[i] + 1'b1) : in_comp[i];
      end
   end

   always_comb begin
      for (int i = 0; i < v4n_pkg::NumComp; i++) begin
         sq_in[i] = v4n_pkg::SqW'(item1_ff.mag[i]) * v4n_pkg::SqW'(item1_ff.mag[i]);
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < v4n_pkg::NumComp; i++) begin
         sum_in = sum_in + v4n_pkg::SumW'(sq_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item1_ff <= item1_in;
         item2_ff <= item1_ff;
         sq_ff    <= sq_in;
         item3_ff <= item2_ff;
         sum_ff   <= sum_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = item3_ff;
   assign out_sum   = sum_ff;

endmodule

`default_nettype wire

[hw/rtl/v4n_sqrt.sv]
`default_nettype none

// one root bit per stage, radicand consumed two bits at a time from the top
module v4n_sqrt (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire v4n_pkg::v4n_item_type    in_item,
   input  wire logic [v4n_pkg::SumW-1:0] in_sum,
   output logic                          out_valid,
   output v4n_pkg::v4n_item_type         out_item,
   output logic [v4n_pkg::RootW-1:0]     out_root
);

   localparam int Steps = v4n_pkg::RootW;

   logic [Steps-1:0]              vld_ff;
   v4n_pkg::v4n_item_type         item_ff [Steps];
   logic [v4n_pkg::SumW-1:0]      rad_ff  [Steps];
   logic [v4n_pkg::RemW-1:0]      rem_ff  [Steps];
   logic [v4n_pkg::RootW-1:0]     root_ff [Steps];

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic                      src_vld;
      v4n_pkg::v4n_item_type     src_item;
      logic [v4n_pkg::SumW-1:0]  src_rad;
      logic [v4n_pkg::RemW-1:0]  src_rem, rem_sh, trial, rem_in;
      logic [v4n_pkg::RootW-1:0] src_root;
      logic                      ge;

      if (s == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_item = in_item;
         assign src_rad  = in_sum;
         assign src_rem  = '0;
         assign src_root = '0;
      end else begin : g_next
         assign src_vld  = vld_ff[s-1];
         assign src_item = item_ff[s-1];
         assign src_rad  = rad_ff[s-1];
         assign src_rem  = rem_ff[s-1];
         assign src_root = root_ff[s-1];
      end

      assign rem_sh = {src_rem[v4n_pkg::RemW-3:0], src_rad[v4n_pkg::SumW-1 -: 2]};
      assign trial  = {1'b0, src_root, 2'b01};
      assign ge     = rem_sh >= trial;
      assign rem_in = ge ? (rem_sh - trial) : rem_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            item_ff[s] <= src_item;
            rad_ff[s]  <= {src_rad[v4n_pkg::SumW-3:0], 2'b00};
            rem_ff[s]  <= rem_in;
            root_ff[s] <= {src_root[v4n_pkg::RootW-2:0], ge};
         end
      end
   end

   assign out_valid = vld_ff[Steps-1];
   assign out_item  = item_ff[Steps-1];
   assign out_root  = root_ff[Steps-1];

endmodule

`default_nettype wire

[hw/rtl/v4n_div.sv]
`default_nettype none

// restoring division, one quotient bit per stage for all four lanes
module v4n_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire v4n_pkg::v4n_item_type     in_item,
   input  wire logic [v4n_pkg::RootW-1:0] in_len,
   output logic                           out_valid,
   output logic [v4n_pkg::NumComp-1:0]    out_neg,
   output logic [v4n_pkg::RootW-1:0]      out_len,
   output logic [v4n_pkg::NumComp-1:0][v4n_pkg::QuotW-1:0] out_quo
);

   localparam int Steps = v4n_pkg::QuotW;
   localparam int NC    = v4n_pkg::NumComp;

   logic [Steps-1:0]                          vld_ff;
   logic [NC-1:0]                             neg_ff [Steps];
   logic [v4n_pkg::RootW-1:0]                 len_ff [Steps];
   logic [NC-1:0][v4n_pkg::DRemW-1:0]         rem_ff [Steps];
   logic [NC-1:0][v4n_pkg::QuotW-1:0]         quo_ff [Steps];

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic                              src_vld;
      logic [NC-1:0]                     src_neg;
      logic [v4n_pkg::RootW-1:0]         src_len;
      logic [NC-1:0][v4n_pkg::DRemW-1:0] src_rem, rem_in;
      logic [NC-1:0][v4n_pkg::QuotW-1:0] src_quo, quo_in;
      logic [NC-1:0]                     shin;

      if (s == 0) begin : g_first
         // dividend is mag << 30; its top part mag >> 1 is already below len
         for (genvar c = 0; c < NC; c++) begin : g_init
            assign src_rem[c] = {2'b00, in_item.mag[c][v4n_pkg::CompW-1:1]};
            assign shin[c]    = in_item.mag[c][0];
         end
         assign src_vld = in_valid;
         assign src_neg = in_item.neg;
         assign src_len = in_len;
         assign src_quo = '0;
      end else begin : g_next
         assign src_vld = vld_ff[s-1];
         assign src_neg = neg_ff[s-1];
         assign src_len = len_ff[s-1];
         assign src_rem = rem_ff[s-1];
         assign src_quo = quo_ff[s-1];
         assign shin    = '0;
      end

      for (genvar c = 0; c < NC; c++) begin : g_lane
         logic [v4n_pkg::DRemW:0] r2, diff;
         logic                    ge;
         assign r2         = {src_rem[c], shin[c]};
         assign ge         = r2 >= {1'b0, src_len};
         assign diff       = r2 - {1'b0, src_len};
         assign rem_in[c]  = ge ? diff[v4n_pkg::DRemW-1:0] : r2[v4n_pkg::DRemW-1:0];
         assign quo_in[c]  = {src_quo[c][v4n_pkg::QuotW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[s] <= src_neg;
            len_ff[s] <= src_len;
            rem_ff[s] <= rem_in;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign out_valid = vld_ff[Steps-1];
   assign out_neg   = neg_ff[Steps-1];
   assign out_len   = len_ff[Steps-1];
   assign out_quo   = quo_ff[Steps-1];

endmodule

`default_nettype wire

[hw/rtl/vector4_normalize.sv]
// vector4_normalize: scales a four-component vector to unit length.
//
// Input channel (req_): one vector per item, four signed Q16.16 components.
// Result channel (rsp_): four signed Q2.30 unit components (rounded toward
// zero), the unsigned Q17.16 length and a zero_length flag. A vector of
// zero length comes back as zeros with zero_length set.
//
// The pipe first takes abs, squares and sum, then the square root (one
// root bit per stage), then the four divisions (one quotient bit per
// stage, four lanes side by side) and last the result register.
// Throughput is one item per cycle while req_stall is low.
//
// Reset clears every valid bit; the pipe is empty after reset.
// When the receiver stalls with a result pending the whole pipe freezes and
// req_stall rises in the same cycle; no item is lost or repeated.
`default_nettype none

module vector4_normalize (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_comp_x,
   input  wire logic [31:0] req_comp_y,
   input  wire logic [31:0] req_comp_z,
   input  wire logic [31:0] req_comp_w,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_unit_x,
   output logic [31:0]      rsp_unit_y,
   output logic [31:0]      rsp_unit_z,
   output logic [31:0]      rsp_unit_w,
   output logic [32:0]      rsp_magnitude,
   output logic             rsp_zero_length
);

   localparam int NC = v4n_pkg::NumComp;

   logic                                     en;
   v4n_pkg::v4n_vec_type                     comp;
   logic                                     sq_valid, rt_valid, dv_valid;
   v4n_pkg::v4n_item_type                    sq_item, rt_item;
   logic [v4n_pkg::SumW-1:0]                 sq_sum;
   logic [v4n_pkg::RootW-1:0]                rt_root, dv_len;
   logic [NC-1:0]                            dv_neg;
   logic [NC-1:0][v4n_pkg::QuotW-1:0]        dv_quo;

   logic                                     valid_ff;
   logic [NC-1:0][v4n_pkg::UnitW-1:0]        unit_in, unit_ff;
   logic [v4n_pkg::RootW-1:0]                mag_ff;
   logic                                     zero_in, zero_ff;

   assign en        = !(valid_ff && rsp_stall);
   assign req_stall = !en;
   assign comp      = {req_comp_w, req_comp_z, req_comp_y, req_comp_x};

   v4n_square u_square (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_comp   (comp),
      .out_valid (sq_valid),
      .out_item  (sq_item),
      .out_sum   (sq_sum)
   );

   v4n_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_item   (sq_item),
      .in_sum    (sq_sum),
      .out_valid (rt_valid),
      .out_item  (rt_item),
      .out_root  (rt_root)
   );

   v4n_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_valid),
      .in_item   (rt_item),
      .in_len    (rt_root),
      .out_valid (dv_valid),
      .out_neg   (dv_neg),
      .out_len   (dv_len),
      .out_quo   (dv_quo)
   );

   // zero length means all inputs were zero; the unit components are forced to zeros
   always_comb begin
      zero_in = (dv_len == '0);
      for (int i = 0; i < NC; i++) begin
         if (zero_in) begin
            unit_in[i] = '0;
         end else if (dv_neg[i]) begin
            unit_in[i] = '0 - {1'b0, dv_quo[i]};
         end else begin
            unit_in[i] = {1'b0, dv_quo[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unit_ff <= unit_in;
         mag_ff  <= dv_len;
         zero_ff <= zero_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_unit_x      = unit_ff[0];
   assign rsp_unit_y      = unit_ff[1];
   assign rsp_unit_z      = unit_ff[2];
   assign rsp_unit_w      = unit_ff[3];
   assign rsp_magnitude   = mag_ff;
   assign rsp_zero_length = zero_ff;

`ifndef ASSERT_OFF
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |-> rsp_magnitude == '0 && rsp_unit_x == '0
         && rsp_unit_y == '0 && rsp_unit_z == '0 && rsp_unit_w == '0)
      else $error("zero-length item with nonzero fields");

   a_nonzero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_length |-> rsp_magnitude != '0)
      else $error("zero magnitude without zero_length flag");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_unit_x) <= 32'sd1073741824)
         && ($signed(rsp_unit_x) >= -32'sd1073741824)
         && ($signed(rsp_unit_w) <= 32'sd1073741824)
         && ($signed(rsp_unit_w) >= -32'sd1073741824))
      else $error("unit component out of range");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("pipe freeze out of step with result stall");
`endif

endmodule

`default_nettype wire
